// ===== sv/tbmof_pkg.sv =====
// Package for the two-bucket minimum offset filter.
// Holds the timestamp width, register indexes, reset values and the sequencer states.
// No dependencies.
package tbmof_pkg;

  // Timestamp bits used out of the 63-bit input fields (range 32..63).
  localparam int unsigned TIME_BITS = 63;
  localparam int unsigned FIELD_W   = 63;
  localparam int unsigned OFFSET_W  = 64;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CNT_W     = $clog2(TIME_BITS);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [TIME_BITS:0]   time_x_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NET_FLOOR = 1'd1;

  localparam logic [CFG_W-1:0] WINDOW_RESET    = 32'd30000000;
  localparam logic [CFG_W-1:0] NET_FLOOR_RESET = 32'd0;

  localparam logic [FIELD_W-1:0] LAT_MAX = {FIELD_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHK,
    ST_DIV,
    ST_ROT,
    ST_UPD,
    ST_FLR,
    ST_EXC,
    ST_LAT
  } state_e;

endpackage

// ===== sv/two_bucket_min_offset_filter.sv =====
// Two-bucket windowed minimum clock offset filter, top level.
// Depends on tbmof_pkg for widths, register indexes and sequencer states.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item: a host and a local
//   timestamp in microseconds. Output channel (out_valid_o / out_stall_i) gives
//   one item per input: raw offset (local minus host), the offset floor over the
//   current and the previous non-empty window, and the latency above the floor
//   plus the network floor, saturated at 2^63-1. An item moves at a clock edge
//   where valid is high and stall is low. cfg_we_i writes cfg_data_i into
//   register cfg_idx_i (0: window length, 1: network floor); write only while idle.
// Sequencing:
//   One item at a time; the input stalls meanwhile. Without a window rotation an
//   item passes the prepare, check, update, floor, excess and latency states;
//   when a window end is passed, a restoring divider works out the remainder of
//   elapsed time over the window length, one bit per cycle, before a rotate step.
//   The next item is taken the cycle after the result is loaded.
// Reset: rst_ni clears the buckets, the first-sample flag and the output valid,
//   and restores the window length to 30 s and the network floor to zero.
// Output stall: the finished item holds in the output register; the next input
//   is accepted and worked on, but its result waits until the register frees.
module two_bucket_min_offset_filter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tbmof_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tbmof_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [tbmof_pkg::FIELD_W-1:0]         host_time_us_i,
  input  logic [tbmof_pkg::FIELD_W-1:0]         local_time_us_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tbmof_pkg::OFFSET_W-1:0] raw_offset_o,
  output logic signed [tbmof_pkg::OFFSET_W-1:0] offset_floor_o,
  output logic [tbmof_pkg::FIELD_W-1:0]         latency_us_o
);

  tbmof_pkg::state_e state_q, state_d;

  // Configuration
  logic [tbmof_pkg::CFG_W-1:0] window_q, net_floor_q;

  // Filter state
  logic                             seen_any_q, prev_valid_q, cur_empty_q;
  logic [tbmof_pkg::OFFSET_W-1:0]   cur_min_q, prev_min_q;
  tbmof_pkg::time_t                 win_begin_q;

  // Per-item working registers
  tbmof_pkg::time_t                 host_q, local_q, elapsed_q, num_q;
  logic                             behind_q, one_win_q;
  logic [tbmof_pkg::OFFSET_W-1:0]   raw_q, floor_q, excess_q;
  logic [tbmof_pkg::CFG_W-1:0]      rem_q;
  tbmof_pkg::cnt_t                  cnt_q;

  // Output register
  logic                             out_valid_q;
  logic [tbmof_pkg::OFFSET_W-1:0]   out_raw_q, out_floor_q;
  logic [tbmof_pkg::FIELD_W-1:0]    out_lat_q;

  // Combinational helpers
  logic [tbmof_pkg::CFG_W-1:0]      win_w;
  logic                             lt_win, lt_two_win;
  logic [tbmof_pkg::CFG_W:0]        trial, win_x;
  logic                             trial_ge;
  logic [tbmof_pkg::CFG_W-1:0]      rem_next;
  logic [tbmof_pkg::OFFSET_W-1:0]   cur_next;
  logic [tbmof_pkg::OFFSET_W:0]     lat_sum;
  logic                             accept_in, load_out;

  // A zero window behaves as a one-microsecond window.
  assign win_w      = (window_q == '0) ? tbmof_pkg::CFG_W'(1) : window_q;
  assign lt_win     = elapsed_q < tbmof_pkg::time_t'(win_w);
  assign lt_two_win = tbmof_pkg::time_x_t'(elapsed_q) < tbmof_pkg::time_x_t'({win_w, 1'b0});

  // Restoring divider step: bring down one numerator bit, subtract if it fits.
  assign win_x    = {1'b0, win_w};
  assign trial    = {rem_q, num_q[tbmof_pkg::TIME_BITS-1]};
  assign trial_ge = trial >= win_x;
  assign rem_next = trial_ge ? tbmof_pkg::CFG_W'(trial - win_x)
                             : trial[tbmof_pkg::CFG_W-1:0];

  // Fresh bucket takes the sample, otherwise keep the signed minimum.
  assign cur_next = (cur_empty_q || ($signed(raw_q) < $signed(cur_min_q))) ? raw_q
                                                                           : cur_min_q;

  assign lat_sum = {1'b0, excess_q} + (tbmof_pkg::OFFSET_W + 1)'(net_floor_q);

  // Handshake decode
  always_comb begin
    in_stall_o = (state_q != tbmof_pkg::ST_IDLE);
    accept_in  = in_valid_i && (state_q == tbmof_pkg::ST_IDLE);
    load_out   = (state_q == tbmof_pkg::ST_LAT) && (!out_valid_q || !out_stall_i);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tbmof_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tbmof_pkg::ST_PREP;
      end
      tbmof_pkg::ST_PREP: state_d = tbmof_pkg::ST_CHK;
      tbmof_pkg::ST_CHK: begin
        // Rotate only once a window end has been passed
        if (!seen_any_q || behind_q || lt_win) state_d = tbmof_pkg::ST_UPD;
        else state_d = tbmof_pkg::ST_DIV;
      end
      tbmof_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = tbmof_pkg::ST_ROT;
      end
      tbmof_pkg::ST_ROT: state_d = tbmof_pkg::ST_UPD;
      tbmof_pkg::ST_UPD: state_d = tbmof_pkg::ST_FLR;
      tbmof_pkg::ST_FLR: state_d = tbmof_pkg::ST_EXC;
      tbmof_pkg::ST_EXC: state_d = tbmof_pkg::ST_LAT;
      tbmof_pkg::ST_LAT: begin
        if (load_out) state_d = tbmof_pkg::ST_IDLE;
      end
      default: state_d = tbmof_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbmof_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= tbmof_pkg::WINDOW_RESET;
      net_floor_q <= tbmof_pkg::NET_FLOOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbmof_pkg::REG_WINDOW:    window_q    <= cfg_data_i;
        tbmof_pkg::REG_NET_FLOOR: net_floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bucket state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_any_q   <= 1'b0;
      prev_valid_q <= 1'b0;
      cur_empty_q  <= 1'b1;
      cur_min_q    <= '0;
      prev_min_q   <= '0;
      win_begin_q  <= '0;
    end else begin
      case (state_q)
        tbmof_pkg::ST_ROT: begin
          // One window passed keeps the closing bucket; more means it was empty
          if (one_win_q) begin
            prev_min_q   <= cur_min_q;
            prev_valid_q <= !cur_empty_q;
          end else begin
            prev_min_q   <= '0;
            prev_valid_q <= 1'b0;
          end
          // Advance to the last window start not after the local time
          win_begin_q <= local_q - tbmof_pkg::time_t'(rem_q);
          cur_min_q   <= '0;
          cur_empty_q <= 1'b1;
        end
        tbmof_pkg::ST_UPD: begin
          if (!seen_any_q) begin
            seen_any_q   <= 1'b1;
            win_begin_q  <= local_q;
            cur_min_q    <= raw_q;
            cur_empty_q  <= 1'b0;
            prev_valid_q <= 1'b0;
          end else begin
            cur_min_q   <= cur_next;
            cur_empty_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      host_q  <= host_time_us_i[tbmof_pkg::TIME_BITS-1:0];
      local_q <= local_time_us_i[tbmof_pkg::TIME_BITS-1:0];
    end
    case (state_q)
      tbmof_pkg::ST_PREP: begin
        raw_q     <= tbmof_pkg::OFFSET_W'(local_q) - tbmof_pkg::OFFSET_W'(host_q);
        elapsed_q <= local_q - win_begin_q;
        behind_q  <= local_q < win_begin_q;
      end
      tbmof_pkg::ST_CHK: begin
        one_win_q <= lt_two_win;
        num_q     <= elapsed_q;
        rem_q     <= '0;
        cnt_q     <= tbmof_pkg::cnt_t'(tbmof_pkg::TIME_BITS - 1);
      end
      tbmof_pkg::ST_DIV: begin
        rem_q <= rem_next;
        num_q <= {num_q[tbmof_pkg::TIME_BITS-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      tbmof_pkg::ST_FLR: begin
        floor_q <= (prev_valid_q && ($signed(prev_min_q) < $signed(cur_min_q))) ? prev_min_q
                                                                                : cur_min_q;
      end
      tbmof_pkg::ST_EXC: begin
        excess_q <= ($signed(raw_q) < $signed(floor_q)) ? '0 : raw_q - floor_q;
      end
      default: ;
    endcase
  end

  // Output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_raw_q   <= raw_q;
      out_floor_q <= floor_q;
      out_lat_q   <= (lat_sum[tbmof_pkg::OFFSET_W:tbmof_pkg::FIELD_W] != '0)
                     ? tbmof_pkg::LAT_MAX : lat_sum[tbmof_pkg::FIELD_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign raw_offset_o   = out_raw_q;
  assign offset_floor_o = out_floor_q;
  assign latency_us_o   = out_lat_q;

endmodule

// ===== sv/tbmof_checker.sv =====
// Port-level checker for the two-bucket minimum offset filter, with its bind.
// Depends on tbmof_pkg and on the two_bucket_min_offset_filter port list.
module tbmof_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [tbmof_pkg::OFFSET_W-1:0] raw_offset_o,
  input logic signed [tbmof_pkg::OFFSET_W-1:0] offset_floor_o,
  input logic [tbmof_pkg::FIELD_W-1:0]         latency_us_o
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(raw_offset_o)
      && $stable(offset_floor_o) && $stable(latency_us_o))
    else $error("stalled output item changed");

  // One item at a time: busy right after an accepted item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while an item is in work");

  // The floor includes this sample, so it never exceeds the offset
  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> offset_floor_o <= raw_offset_o)
    else $error("offset floor above raw offset");

endmodule

bind two_bucket_min_offset_filter tbmof_checker u_tbmof_checker (.*);
